// ----- hw/rtl/ipsm_pkg.sv -----
package ipsm_pkg;

  localparam int unsigned CLUSTER_SLOTS_DEF = 16;
  localparam int unsigned WORD_AW           = 10;
  localparam int unsigned WORDS_PER_CLUSTER = 1 << WORD_AW;
  localparam int unsigned COUNT_W           = 21;
  localparam int unsigned POP_W             = 17;
  localparam int unsigned IP_W              = 32;
  localparam int unsigned KEY_W             = 16;
  localparam int unsigned BIT_W             = 6;
  localparam int unsigned QUEUE_DEPTH       = 2;

  localparam logic [IP_W-1:0] NONE_VALUE  = '1;
  localparam logic [1:0]      MODE_INSERT = 2'd0;
  localparam logic [1:0]      MODE_DELETE = 2'd1;

  typedef enum logic [1:0] {
    OP_INSERT,
    OP_DELETE,
    OP_QUERY
  } op_e;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_EXEC
  } back_state_e;

  typedef struct packed {
    logic [1:0]      mode;
    logic [IP_W-1:0] ip;
  } req_t;

  typedef struct packed {
    logic               was_present;
    logic               table_full;
    logic [COUNT_W-1:0] element_count;
    logic [IP_W-1:0]    min_value;
    logic [IP_W-1:0]    max_value;
  } rsp_t;

  // Classified request as it travels from the front to the back.
  typedef struct packed {
    op_e                op;
    logic [KEY_W-1:0]   key;
    logic [WORD_AW-1:0] word_off;
    logic [BIT_W-1:0]   bit_idx;
    logic [IP_W-1:0]    ip;
  } cmd_t;

  // Signed compare on raw bit patterns.
  function automatic logic signed_less(logic [IP_W-1:0] a, logic [IP_W-1:0] b);
    return $signed(a) < $signed(b);
  endfunction

endpackage

// ----- hw/rtl/ipsm_if.sv -----
interface ipsm_req_if;
  logic          valid;
  logic          ready;
  ipsm_pkg::req_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface ipsm_rsp_if;
  logic          valid;
  logic          ready;
  ipsm_pkg::rsp_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ----- hw/rtl/two_level_ip_set_membership.sv -----
// A request accepted into the queue is held in a queue entry, then its bitmap word is
// read into the read registers, then updated, written back and put in the result register.
// The back end takes no new request until the read-modify-write of one bitmap word is
// done: the word is read, and then written back in the cycle after.
// Reset: after rst_ni is released the bitmap is cleared one word a cycle, all
// CLUSTER_SLOTS*1024 words, during which up to two requests are queued.
module two_level_ip_set_membership #(
  parameter int unsigned CLUSTER_SLOTS = ipsm_pkg::CLUSTER_SLOTS_DEF
) (
  input logic        clk_i,
  input logic        rst_ni,
  ipsm_req_if.sink   req_i,
  ipsm_rsp_if.source rsp_o
);

  logic           push_valid, push_ready, pop_valid, pop;
  ipsm_pkg::cmd_t push_cmd, pop_cmd;

  ipsm_front u_front (
    .req_i        (req_i),
    .push_valid_o (push_valid),
    .push_cmd_o   (push_cmd),
    .push_ready_i (push_ready)
  );

  ipsm_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_cmd_i   (push_cmd),
    .push_ready_o (push_ready),
    .pop_valid_o  (pop_valid),
    .pop_cmd_o    (pop_cmd),
    .pop_i        (pop)
  );

  ipsm_back #(
    .CLUSTER_SLOTS (CLUSTER_SLOTS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (pop_valid),
    .cmd_i       (pop_cmd),
    .cmd_pop_o   (pop),
    .rsp_o       (rsp_o)
  );

endmodule

// ----- hw/rtl/ipsm_front.sv -----
module ipsm_front (
  ipsm_req_if.sink           req_i,
  output logic               push_valid_o,
  output ipsm_pkg::cmd_t     push_cmd_o,
  input  logic               push_ready_i
);

  always_comb begin
    push_cmd_o.ip       = req_i.data.ip;
    push_cmd_o.key      = req_i.data.ip[31:16];
    push_cmd_o.word_off = req_i.data.ip[15:6];
    push_cmd_o.bit_idx  = req_i.data.ip[5:0];
    // The unused mode code behaves as a query.
    unique case (req_i.data.mode)
      ipsm_pkg::MODE_INSERT: push_cmd_o.op = ipsm_pkg::OP_INSERT;
      ipsm_pkg::MODE_DELETE: push_cmd_o.op = ipsm_pkg::OP_DELETE;
      default:               push_cmd_o.op = ipsm_pkg::OP_QUERY;
    endcase
  end

  assign push_valid_o = req_i.valid;
  assign req_i.ready  = push_ready_i;

endmodule

// ----- hw/rtl/ipsm_queue.sv -----
module ipsm_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_valid_i,
  input  ipsm_pkg::cmd_t push_cmd_i,
  output logic           push_ready_o,
  output logic           pop_valid_o,
  output ipsm_pkg::cmd_t pop_cmd_o,
  input  logic           pop_i
);

  ipsm_pkg::cmd_t entry_q [ipsm_pkg::QUEUE_DEPTH];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] cnt_q, cnt_d;
  logic       push, pop;

  assign push_ready_o = cnt_q != 2'(ipsm_pkg::QUEUE_DEPTH);
  assign pop_valid_o  = cnt_q != 2'd0;
  assign pop_cmd_o    = entry_q[rd_ptr_q];
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_i && pop_valid_o;

  always_comb begin
    wr_ptr_d = push ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = pop ? ~rd_ptr_q : rd_ptr_q;
    cnt_d    = cnt_q + 2'(push) - 2'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      entry_q[wr_ptr_q] <= push_cmd_i;
    end
  end

endmodule

// ----- hw/rtl/ipsm_back.sv -----
module ipsm_back #(
  parameter int unsigned CLUSTER_SLOTS = ipsm_pkg::CLUSTER_SLOTS_DEF
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           cmd_valid_i,
  input  ipsm_pkg::cmd_t cmd_i,
  output logic           cmd_pop_o,
  ipsm_rsp_if.source     rsp_o
);

  localparam int unsigned SW    = (CLUSTER_SLOTS > 1) ? $clog2(CLUSTER_SLOTS) : 1;
  localparam int unsigned AW    = SW + ipsm_pkg::WORD_AW;
  localparam int unsigned DEPTH = CLUSTER_SLOTS * ipsm_pkg::WORDS_PER_CLUSTER;

  ipsm_pkg::back_state_e state_q, state_d;

  // Slot directory, compared in parallel.
  logic [ipsm_pkg::KEY_W-1:0] key_q [CLUSTER_SLOTS];
  logic [CLUSTER_SLOTS-1:0]   valid_q, valid_d;

  logic [63:0]                bmp_mem [DEPTH];
  logic [ipsm_pkg::POP_W-1:0] pop_mem [CLUSTER_SLOTS];
  logic [63:0]                word_rd_q;
  logic [ipsm_pkg::POP_W-1:0] pop_rd_q;

  logic [AW-1:0] clr_q, clr_d;

  ipsm_pkg::cmd_t cmd_q;
  logic           hit_q, free_ok_q;
  logic [SW-1:0]  slot_q;

  logic [ipsm_pkg::COUNT_W-1:0] count_q, count_d;
  logic [ipsm_pkg::IP_W-1:0]    min_q, min_d, max_q, max_d;

  logic           out_valid_q, out_valid_d;
  ipsm_pkg::rsp_t out_q, out_d;

  logic          hit, free_ok;
  logic [SW-1:0] hit_idx, free_idx;
  logic          take, out_free;
  logic          present, do_ins, do_del, full;
  logic [63:0]   base, mask, wr_data;
  logic [ipsm_pkg::POP_W-1:0] pop_base, pop_new;
  logic          wr_en;
  logic [AW-1:0] wr_addr;

  // Lowest matching slot and lowest free slot.
  always_comb begin
    hit      = 1'b0;
    hit_idx  = '0;
    free_ok  = 1'b0;
    free_idx = '0;
    for (int i = CLUSTER_SLOTS - 1; i >= 0; i--) begin
      if (valid_q[i] && key_q[i] == cmd_i.key) begin
        hit     = 1'b1;
        hit_idx = SW'(i);
      end
      if (!valid_q[i]) begin
        free_ok  = 1'b1;
        free_idx = SW'(i);
      end
    end
  end

  assign out_free  = !out_valid_q || rsp_o.ready;
  assign take      = (state_q == ipsm_pkg::ST_IDLE) && cmd_valid_i && out_free;
  assign cmd_pop_o = take;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ipsm_pkg::ST_CLEAR: if (clr_q == AW'(DEPTH - 1)) state_d = ipsm_pkg::ST_IDLE;
      ipsm_pkg::ST_IDLE:  if (take) state_d = ipsm_pkg::ST_EXEC;
      ipsm_pkg::ST_EXEC:  state_d = ipsm_pkg::ST_IDLE;
      default:            state_d = ipsm_pkg::ST_CLEAR;
    endcase
  end

  // Execute step: the word and the population read in the previous cycle are
  // now registered.
  always_comb begin
    present  = hit_q && word_rd_q[cmd_q.bit_idx];
    base     = hit_q ? word_rd_q : '0;
    pop_base = hit_q ? pop_rd_q : '0;
    mask     = 64'd1 << cmd_q.bit_idx;
    do_ins   = (cmd_q.op == ipsm_pkg::OP_INSERT) && !present && (hit_q || free_ok_q);
    full     = (cmd_q.op == ipsm_pkg::OP_INSERT) && !present && !hit_q && !free_ok_q;
    do_del   = (cmd_q.op == ipsm_pkg::OP_DELETE) && present;
    wr_data  = do_ins ? (base | mask) : (base & ~mask);
    pop_new  = do_ins ? pop_base + 1'b1 : pop_base - 1'b1;
  end

  always_comb begin
    clr_d       = clr_q;
    valid_d     = valid_q;
    count_d     = count_q;
    min_d       = min_q;
    max_d       = max_q;
    out_valid_d = out_valid_q && !rsp_o.ready;
    out_d       = out_q;
    wr_en       = 1'b0;
    wr_addr     = {slot_q, cmd_q.word_off};
    unique case (state_q)
      ipsm_pkg::ST_CLEAR: begin
        wr_en   = 1'b1;
        wr_addr = clr_q;
        clr_d   = clr_q + 1'b1;
      end
      ipsm_pkg::ST_EXEC: begin
        wr_en = do_ins || do_del;
        if (do_ins) begin
          valid_d[slot_q] = 1'b1;
          count_d         = count_q + 1'b1;
          if (min_q == ipsm_pkg::NONE_VALUE || ipsm_pkg::signed_less(cmd_q.ip, min_q)) begin
            min_d = cmd_q.ip;
          end
          if (max_q == ipsm_pkg::NONE_VALUE || ipsm_pkg::signed_less(max_q, cmd_q.ip)) begin
            max_d = cmd_q.ip;
          end
        end
        if (do_del) begin
          if (pop_new == '0) valid_d[slot_q] = 1'b0;
          count_d = count_q - 1'b1;
          if (count_d == '0) begin
            min_d = ipsm_pkg::NONE_VALUE;
            max_d = ipsm_pkg::NONE_VALUE;
          end
        end
        out_valid_d         = 1'b1;
        out_d.was_present   = present;
        out_d.table_full    = full;
        out_d.element_count = count_d;
        out_d.min_value     = min_d;
        out_d.max_value     = max_d;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ipsm_pkg::ST_CLEAR;
      clr_q       <= '0;
      valid_q     <= '0;
      count_q     <= '0;
      min_q       <= ipsm_pkg::NONE_VALUE;
      max_q       <= ipsm_pkg::NONE_VALUE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      valid_q     <= valid_d;
      count_q     <= count_d;
      min_q       <= min_d;
      max_q       <= max_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
    if (take) begin
      cmd_q     <= cmd_i;
      hit_q     <= hit;
      free_ok_q <= free_ok;
      slot_q    <= hit ? hit_idx : free_idx;
    end
    if ((state_q == ipsm_pkg::ST_EXEC) && do_ins && !hit_q) begin
      key_q[slot_q] <= cmd_q.key;
    end
  end

  // Bitmap memory: one read and one write port.
  always_ff @(posedge clk_i) begin
    if (take) begin
      word_rd_q <= bmp_mem[{hit_idx, cmd_i.word_off}];
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      bmp_mem[wr_addr] <= (state_q == ipsm_pkg::ST_CLEAR) ? 64'd0 : wr_data;
    end
  end

  // Population memory.
  always_ff @(posedge clk_i) begin
    if (take) begin
      pop_rd_q <= pop_mem[hit_idx];
    end
    if ((state_q == ipsm_pkg::ST_EXEC) && (do_ins || do_del)) begin
      pop_mem[slot_q] <= pop_new;
    end
  end

  assign rsp_o.valid = out_valid_q;
  assign rsp_o.data  = out_q;

endmodule

// ----- tb/ipsm_checker.sv -----
module ipsm_checker (
  input  logic       clk_i,
  input  logic       rst_ni,
  ipsm_req_if        req_i,
  ipsm_rsp_if        rsp_i,
  output int         fail_count_o,
  output int         pending_o,
  output int         full_seen_o
);
  import ipsm_pkg::*;

  localparam int NUM_SLOTS = CLUSTER_SLOTS_DEF;

  // Shadow copy of the set: one entry per address that is present.
  bit                  addr_present [bit [IP_W-1:0]];
  bit [KEY_W-1:0]      slot_owner   [NUM_SLOTS];
  bit                  slot_busy    [NUM_SLOTS];
  bit [POP_W-1:0]      slot_fill    [NUM_SLOTS];
  bit [COUNT_W-1:0]    set_size;
  bit [IP_W-1:0]       low_addr;
  bit [IP_W-1:0]       high_addr;
  rsp_t                expected_rsps [$];

  function automatic int owning_slot(bit [KEY_W-1:0] key);
    for (int i = 0; i < NUM_SLOTS; i++)
      if (slot_busy[i] && slot_owner[i] == key) return i;
    return -1;
  endfunction

  function automatic int first_free_slot();
    for (int i = 0; i < NUM_SLOTS; i++)
      if (!slot_busy[i]) return i;
    return -1;
  endfunction

  // Applies one request to the shadow set and returns the response it should give.
  function automatic rsp_t apply_request(req_t r);
    rsp_t           res;
    bit [KEY_W-1:0] key;
    int             slot;
    bit             hit;
    bit             full;
    key  = r.ip[IP_W-1:KEY_W];
    slot = owning_slot(key);
    hit  = (slot >= 0) && addr_present.exists(r.ip);
    full = 1'b0;
    case (op_e'(r.mode))
      OP_INSERT: begin
        if (!hit) begin
          if (slot < 0) begin
            slot = first_free_slot();
            if (slot >= 0) begin
              slot_busy[slot]  = 1'b1;
              slot_owner[slot] = key;
              slot_fill[slot]  = '0;
            end else begin
              full = 1'b1;
            end
          end
          if (!full) begin
            addr_present[r.ip] = 1'b1;
            slot_fill[slot]    = slot_fill[slot] + 1'b1;
            set_size           = set_size + 1'b1;
            if (low_addr == NONE_VALUE || $signed(r.ip) < $signed(low_addr))
              low_addr = r.ip;
            if (high_addr == NONE_VALUE || $signed(high_addr) < $signed(r.ip))
              high_addr = r.ip;
          end
        end
      end
      OP_DELETE: begin
        if (hit) begin
          addr_present.delete(r.ip);
          slot_fill[slot] = slot_fill[slot] - 1'b1;
          if (slot_fill[slot] == '0) slot_busy[slot] = 1'b0;
          set_size = set_size - 1'b1;
          if (set_size == '0) begin
            low_addr  = NONE_VALUE;
            high_addr = NONE_VALUE;
          end
        end
      end
      default: ;  // Query and the unused mode leave the set alone.
    endcase
    res.was_present   = hit;
    res.table_full    = full;
    res.element_count = set_size;
    res.min_value     = low_addr;
    res.max_value     = high_addr;
    return res;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    rsp_t want;
    rsp_t got;
    int   errs;
    errs = 0;
    if (!rst_ni) begin
      addr_present.delete();
      for (int i = 0; i < NUM_SLOTS; i++) begin
        slot_owner[i] = '0;
        slot_busy[i]  = 1'b0;
        slot_fill[i]  = '0;
      end
      set_size  = '0;
      low_addr  = NONE_VALUE;
      high_addr = NONE_VALUE;
      expected_rsps.delete();
      fail_count_o <= 0;
      full_seen_o  <= 0;
    end else begin
      if (rsp_i.valid && rsp_i.ready) begin
        got = rsp_i.data;
        if (expected_rsps.size() == 0) begin
          $error("response with no request outstanding: %p", got);
          errs++;
        end else begin
          want = expected_rsps.pop_front();
          if (got.was_present !== want.was_present) begin
            $error("was_present: expected %0d, got %0d", want.was_present, got.was_present);
            errs++;
          end
          if (got.table_full !== want.table_full) begin
            $error("table_full: expected %0d, got %0d", want.table_full, got.table_full);
            errs++;
          end
          if (got.element_count !== want.element_count) begin
            $error("element_count: expected %0d, got %0d",
                   want.element_count, got.element_count);
            errs++;
          end
          if (got.min_value !== want.min_value) begin
            $error("min_value: expected %h, got %h", want.min_value, got.min_value);
            errs++;
          end
          if (got.max_value !== want.max_value) begin
            $error("max_value: expected %h, got %h", want.max_value, got.max_value);
            errs++;
          end
          if (want.table_full) full_seen_o <= full_seen_o + 1;
        end
      end
      fail_count_o <= fail_count_o + errs;
      if (req_i.valid && req_i.ready)
        expected_rsps.push_back(apply_request(req_i.data));
    end
  end

  assign pending_o = expected_rsps.size();

endmodule

// ----- tb/tb_two_level_ip_set_membership.sv -----
module tb_two_level_ip_set_membership;
  import ipsm_pkg::*;

  localparam logic [1:0] MODE_UNUSED = 2'd3;
  localparam int         CYCLE_LIMIT = 800000;
  localparam int         RANDOM_REQS = 850;
  localparam int         HOLD_CYCLES = 300;

  logic clk_i;
  logic rst_ni;

  ipsm_req_if req_if ();
  ipsm_rsp_if rsp_if ();

  int fail_count;
  int pending;
  int full_seen;
  int cycles;
  int send_idle_pct;
  int recv_stall_pct;
  int sent_per_mode [4];
  logic long_hold_req;
  logic long_hold_done;
  int   hold_left;
  logic [IP_W-1:0]  live_addrs [$];
  logic [KEY_W-1:0] key_pool [20];

  two_level_ip_set_membership dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_if),
    .rsp_o  (rsp_if)
  );

  ipsm_checker u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .req_i        (req_if),
    .rsp_i        (rsp_if),
    .fail_count_o (fail_count),
    .pending_o    (pending),
    .full_seen_o  (full_seen)
  );

  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("[two_level_ip_set_membership] ERROR");
      $finish;
    end
  end

  // Response side: random stalls, plus one long hold-off on request.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rsp_if.ready   <= 1'b0;
      hold_left      <= 0;
      long_hold_done <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left    <= hold_left - 1;
      rsp_if.ready <= 1'b0;
      if (hold_left == 1) long_hold_done <= 1'b1;
    end else if (long_hold_req && !long_hold_done) begin
      hold_left    <= HOLD_CYCLES;
      rsp_if.ready <= 1'b0;
    end else begin
      rsp_if.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  task automatic send_req(input logic [1:0] m, input logic [IP_W-1:0] a);
    req_if.valid   <= 1'b1;
    req_if.data.mode <= m;
    req_if.data.ip   <= a;
    do @(posedge clk_i); while (!req_if.ready);
    sent_per_mode[m]++;
    if (m == MODE_INSERT) begin
      if (live_addrs.size() < 400) live_addrs.push_back(a);
    end
    if (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
      req_if.valid <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < send_idle_pct);
    end
  endtask

  task automatic wait_drained();
    req_if.valid <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
  endtask

  function automatic logic [IP_W-1:0] pick_addr();
    logic [15:0] low;
    if ($urandom_range(99) < 25) return $urandom;
    low = ($urandom_range(1) != 0) ? 16'($urandom_range(63)) : 16'($urandom);
    return {key_pool[$urandom_range(19)], low};
  endfunction

  // Removes everything the stimulus believes to be in the set.
  task automatic empty_set();
    while (live_addrs.size() > 0)
      send_req(MODE_DELETE, live_addrs.pop_front());
  endtask

  task automatic random_req();
    int sel;
    int idx;
    sel = $urandom_range(99);
    if (sel < 42) begin
      send_req(MODE_INSERT, pick_addr());
    end else if (sel < 72) begin
      if (live_addrs.size() > 0 && $urandom_range(3) != 0) begin
        idx = $urandom_range(live_addrs.size() - 1);
        send_req(MODE_DELETE, live_addrs[idx]);
        live_addrs.delete(idx);
      end else begin
        send_req(MODE_DELETE, pick_addr());
      end
    end else if (sel < 95) begin
      if (live_addrs.size() > 0 && $urandom_range(1) != 0)
        send_req(2'(OP_QUERY), live_addrs[$urandom_range(live_addrs.size() - 1)]);
      else
        send_req(2'(OP_QUERY), pick_addr());
    end else begin
      send_req(MODE_UNUSED, pick_addr());
    end
  endtask

  initial begin
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    long_hold_req  = 1'b0;
    rst_ni         = 1'b0;
    req_if.valid   <= 1'b0;
    req_if.data    <= '0;
    key_pool[0] = 16'h0000;
    key_pool[1] = 16'hFFFF;
    key_pool[2] = 16'h8000;
    key_pool[3] = 16'h7FFF;
    for (int i = 4; i < 20; i++) key_pool[i] = 16'($urandom);
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Extremes and sentinel handling, then fill every cluster slot.
    send_req(MODE_INSERT, 32'h0000_0000);
    send_req(MODE_INSERT, 32'hFFFF_FFFF);
    send_req(MODE_INSERT, 32'h8000_0000);
    send_req(MODE_INSERT, 32'h7FFF_FFFF);
    send_req(MODE_INSERT, 32'h7FFF_FFFF);
    send_req(2'(OP_QUERY), 32'h8000_0000);
    send_req(MODE_UNUSED, 32'hFFFF_FFFF);
    send_req(MODE_DELETE, 32'h1234_5678);
    for (int k = 1; k <= 12; k++)
      send_req(MODE_INSERT, {16'(k), 16'(k * 16'h1111)});
    send_req(MODE_INSERT, 32'h0F0F_0001);  // no slot left
    send_req(MODE_DELETE, 32'h0000_0000);  // frees the lowest slot
    send_req(MODE_INSERT, 32'h0F0F_0001);
    empty_set();                            // min and max back to none
    wait_drained();

    for (int i = 0; i < RANDOM_REQS; i++) begin
      case ((i / 100) % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 62; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 62; end
        default: begin send_idle_pct = 19; recv_stall_pct = 19; end
      endcase
      if (i == 150) long_hold_req = 1'b1;
      if (i == 450) wait_drained();
      if (i == 500) empty_set();
      random_req();
    end
    long_hold_req = 1'b0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    empty_set();
    req_if.valid <= 1'b0;

    while (pending != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    $display("covered %0d inserts, %0d deletes, %0d queries, %0d spare-mode requests",
             sent_per_mode[0], sent_per_mode[1], sent_per_mode[2], sent_per_mode[3]);
    $display("refused inserts on a full slot table: %0d, long hold-off done: %0d",
             full_seen, long_hold_done);
    if (fail_count == 0)
      $display("[two_level_ip_set_membership] OK");
    else
      $display("[two_level_ip_set_membership] ERROR");
    $finish;
  end

endmodule

// ----- two_level_ip_set_membership.f -----
hw/rtl/ipsm_pkg.sv
hw/rtl/ipsm_if.sv
hw/rtl/ipsm_front.sv
hw/rtl/ipsm_queue.sv
hw/rtl/ipsm_back.sv
hw/rtl/two_level_ip_set_membership.sv
tb/ipsm_checker.sv
tb/tb_two_level_ip_set_membership.sv
